/* design/rsol_pkg.sv */
// ----------------------------------------------------------------------------
// rsol_pkg
// Shared types and constants of the ring entry store with offset lookup.
// ----------------------------------------------------------------------------
package rsol_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int LEN_W       = 32;
    localparam int HANDLE_W    = 32;
    localparam int OFFSET_W    = 32;
    localparam int SLOT_OUT_W  = 4;
    localparam int S_DATA_W    = LEN_W + HANDLE_W + OFFSET_W;
    localparam int M_DATA_W    = 104;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_FIND = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_HOLD = 3'b100
    } state_t;

    // write control broadcast to every cell
    typedef struct packed {
        logic                shift;
        logic                append;
        logic [LEN_W-1:0]    len;
        logic [HANDLE_W-1:0] handle;
    } wr_t;

    // search token handed from cell to cell
    typedef struct packed {
        logic                  valid;
        logic                  hit;
        logic [OFFSET_W-1:0]   rem;
        logic [SLOT_OUT_W-1:0] slot;
        logic [HANDLE_W-1:0]   handle;
    } token_t;

    // result item, last field in the lowest bits
    typedef struct packed {
        logic [OFFSET_W-1:0]   byte_in_entry;
        logic [HANDLE_W-1:0]   found_handle;
        logic [SLOT_OUT_W-1:0] found_slot;
        logic                  found;
        logic [HANDLE_W-1:0]   evicted_handle;
        logic                  evicted_valid;
        logic                  add_accepted;
    } result_t;

endpackage

/* design/rsol_cell.sv */
// ----------------------------------------------------------------------------
// rsol_cell
// One entry of the age-ordered chain plus one stage of the search token path.
// ----------------------------------------------------------------------------
module rsol_cell #(
    parameter int ENTRIES = rsol_pkg::ENTRIES_DEF,
    parameter int INDEX   = 0,
    localparam int SLOT_W = $clog2(ENTRIES),
    localparam int CNT_W  = $clog2(ENTRIES + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rsol_pkg::wr_t                  wr,
    input  logic [SLOT_W-1:0]              new_slot,
    input  logic [CNT_W-1:0]               count,
    input  logic [rsol_pkg::LEN_W-1:0]     nb_len,
    input  logic [rsol_pkg::HANDLE_W-1:0]  nb_handle,
    input  logic [SLOT_W-1:0]              nb_slot,
    output logic [rsol_pkg::LEN_W-1:0]     len,
    output logic [rsol_pkg::HANDLE_W-1:0]  handle,
    output logic [SLOT_W-1:0]              slot,
    input  rsol_pkg::token_t               tok_in,
    output rsol_pkg::token_t               tok_out
);

    logic [rsol_pkg::LEN_W-1:0]    len_reg;
    logic [rsol_pkg::HANDLE_W-1:0] handle_reg;
    logic [SLOT_W-1:0]             slot_reg;
    rsol_pkg::token_t              tok_reg;
    rsol_pkg::token_t              tok_next;
    logic                          occupied;
    logic                          append_here;

    assign occupied    = CNT_W'(INDEX) < count;
    assign append_here = wr.append && (count == CNT_W'(INDEX));

    // entries move one cell towards the head when the oldest is evicted
    always_ff @(posedge clk)
    begin
        if (wr.shift)
        begin
            len_reg    <= nb_len;
            handle_reg <= nb_handle;
            slot_reg   <= nb_slot;
        end
        else if (append_here)
        begin
            len_reg    <= wr.len;
            handle_reg <= wr.handle;
            slot_reg   <= new_slot;
        end
    end

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && !tok_in.hit && occupied)
        begin
            if (tok_in.rem < len_reg)
            begin
                tok_next.hit    = 1'b1;
                tok_next.slot   = rsol_pkg::SLOT_OUT_W'(slot_reg);
                tok_next.handle = handle_reg;
            end
            else
            begin
                tok_next.rem = tok_in.rem - len_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign len     = len_reg;
    assign handle  = handle_reg;
    assign slot    = slot_reg;
    assign tok_out = tok_reg;

endmodule

/* design/ring_entry_store_offset_lookup.sv */
// ----------------------------------------------------------------------------
// ring_entry_store_offset_lookup
// Ring of length/handle entries with eviction of the oldest and offset lookup.
// ----------------------------------------------------------------------------
// Input channel s_*: one transfer per item. s_tuser is the kind (add or find),
// s_tdata carries entry_length, entry_handle and the lookup position.
// Output channel m_*: exactly one result transfer per input item, in order.
// Entries sit in a chain of ENTRIES cells ordered by age, oldest at the head;
// each cell also remembers the ring slot it was written to.
// An add's result goes to the output register at the transfer edge, and
// adds can follow back to back while the output is being drained.
// A find launches a token down the cell chain, one cell per cycle, subtracting
// each stored length until the offset falls inside an entry. The token runs via
// the launch register and every cell's token register to a result register;
// no new item is taken until that result has moved to the output register.
// Reset empties the ring (count, write slot and token stages cleared); entry
// contents are not cleared. While m_tready is low a waiting result holds and
// no further item is taken once the single output register is occupied.
// ----------------------------------------------------------------------------
module ring_entry_store_offset_lookup #(
    parameter int ENTRIES = rsol_pkg::ENTRIES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // entry_length[31:0], entry_handle[63:32], lookup_pos[95:64]
    input  logic [rsol_pkg::S_DATA_W-1:0] s_tdata,
    // kind[0]
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // add_accepted[0], evicted_valid[1], evicted_handle[33:2], found[34],
    // found_slot[38:35], found_handle[70:39], byte_in_entry[102:71], zero[103]
    output logic [rsol_pkg::M_DATA_W-1:0] m_tdata
);

    localparam int SLOT_W = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    rsol_pkg::state_t  state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    rsol_pkg::token_t  launch_reg, launch_next;
    rsol_pkg::result_t res_reg, res_next;
    rsol_pkg::result_t out_reg, out_next;
    logic              m_tvalid_reg, m_tvalid_next;

    logic [rsol_pkg::LEN_W-1:0]    in_len;
    logic [rsol_pkg::HANDLE_W-1:0] in_handle;
    logic [rsol_pkg::OFFSET_W-1:0] in_offset;
    logic                          in_fire;
    logic                          add_fire;
    logic                          find_fire;
    logic                          add_ok;
    logic                          full;
    logic                          out_free;
    rsol_pkg::wr_t                 wr;
    rsol_pkg::result_t             add_res;
    rsol_pkg::result_t             find_res;

    logic [rsol_pkg::LEN_W-1:0]    cell_len    [ENTRIES];
    logic [rsol_pkg::HANDLE_W-1:0] cell_handle [ENTRIES];
    logic [SLOT_W-1:0]             cell_slot   [ENTRIES];
    rsol_pkg::token_t              tok         [ENTRIES+1];

    assign in_len    = s_tdata[rsol_pkg::LEN_W-1:0];
    assign in_handle = s_tdata[rsol_pkg::LEN_W+rsol_pkg::HANDLE_W-1:rsol_pkg::LEN_W];
    assign in_offset = s_tdata[rsol_pkg::S_DATA_W-1:rsol_pkg::LEN_W+rsol_pkg::HANDLE_W];

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = (state_reg == rsol_pkg::ST_IDLE) && out_free;
    assign in_fire   = s_tvalid && s_tready;
    assign add_fire  = in_fire && (s_tuser == rsol_pkg::KIND_ADD);
    assign find_fire = in_fire && (s_tuser == rsol_pkg::KIND_FIND);
    assign add_ok    = add_fire && (in_len != '0) && (in_handle != '0);
    assign full      = count_reg == CNT_W'(ENTRIES);

    always_comb
    begin
        wr.shift  = add_ok && full;
        wr.append = add_ok && !full;
        wr.len    = in_len;
        wr.handle = in_handle;
    end

    assign tok[0] = launch_reg;

    genvar k;
    generate
        for (k = 0; k < ENTRIES; k++)
        begin : g_cell
            logic [rsol_pkg::LEN_W-1:0]    nb_len;
            logic [rsol_pkg::HANDLE_W-1:0] nb_handle;
            logic [SLOT_W-1:0]             nb_slot;

            // the tail cell takes the new entry when the chain shifts
            if (k == ENTRIES - 1)
            begin : g_tail
                assign nb_len    = in_len;
                assign nb_handle = in_handle;
                assign nb_slot   = write_slot_reg;
            end
            else
            begin : g_body
                assign nb_len    = cell_len[k+1];
                assign nb_handle = cell_handle[k+1];
                assign nb_slot   = cell_slot[k+1];
            end

            rsol_cell #(
                .ENTRIES (ENTRIES),
                .INDEX   (k)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .wr        (wr),
                .new_slot  (write_slot_reg),
                .count     (count_reg),
                .nb_len    (nb_len),
                .nb_handle (nb_handle),
                .nb_slot   (nb_slot),
                .len       (cell_len[k]),
                .handle    (cell_handle[k]),
                .slot      (cell_slot[k]),
                .tok_in    (tok[k]),
                .tok_out   (tok[k+1])
            );
        end
    endgenerate

    always_comb
    begin
        add_res                = '0;
        add_res.add_accepted   = add_ok;
        add_res.evicted_valid  = add_ok && full;
        add_res.evicted_handle = (add_ok && full) ? cell_handle[0] : '0;
    end

    always_comb
    begin
        find_res               = '0;
        find_res.found         = tok[ENTRIES].hit;
        find_res.found_slot    = tok[ENTRIES].hit ? tok[ENTRIES].slot : '0;
        find_res.found_handle  = tok[ENTRIES].hit ? tok[ENTRIES].handle : '0;
        find_res.byte_in_entry = tok[ENTRIES].hit ? tok[ENTRIES].rem : '0;
    end

    always_comb
    begin
        count_next      = count_reg;
        write_slot_next = write_slot_reg;
        if (add_ok)
        begin
            if (!full)
            begin
                count_next = count_reg + CNT_W'(1);
            end
            if (write_slot_reg == SLOT_W'(ENTRIES - 1))
            begin
                write_slot_next = '0;
            end
            else
            begin
                write_slot_next = write_slot_reg + SLOT_W'(1);
            end
        end
    end

    always_comb
    begin
        launch_next       = '0;
        launch_next.valid = find_fire;
        launch_next.rem   = in_offset;
    end

    always_comb
    begin
        state_next    = state_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        m_tvalid_next = m_tvalid_reg;
        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            rsol_pkg::ST_IDLE:
            begin
                if (add_fire)
                begin
                    out_next      = add_res;
                    m_tvalid_next = 1'b1;
                end
                else if (find_fire)
                begin
                    state_next = rsol_pkg::ST_WALK;
                end
            end
            rsol_pkg::ST_WALK:
            begin
                if (tok[ENTRIES].valid)
                begin
                    res_next   = find_res;
                    state_next = rsol_pkg::ST_HOLD;
                end
            end
            rsol_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    out_next      = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = rsol_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rsol_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= rsol_pkg::ST_IDLE;
            count_reg      <= '0;
            write_slot_reg <= '0;
            launch_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            write_slot_reg <= write_slot_next;
            launch_reg     <= launch_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, out_reg};

endmodule

/* tb/ring_entry_store_offset_lookup_test.sv */
// ----------------------------------------------------------------------------
// ring_entry_store_offset_lookup_test
// Drives add and find items into the ring store through the input stream and
// checks every result transfer, field by field, against a behavioural copy of
// the ring kept inside this bench. A short table of directed items comes
// first, then randomised traffic with random gaps and output back-pressure.
// ----------------------------------------------------------------------------
module ring_entry_store_offset_lookup_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = rsol_pkg::ENTRIES_DEF;
    localparam int RAND_ITEMS  = 1950;
    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic                          kind;
        logic [rsol_pkg::LEN_W-1:0]    len;
        logic [rsol_pkg::HANDLE_W-1:0] hnd;
        logic [rsol_pkg::OFFSET_W-1:0] off;
        bit                            typed;
        rsol_pkg::result_t             want;
    } dir_row_t;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [rsol_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic                          s_tuser  = rsol_pkg::KIND_ADD;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [rsol_pkg::M_DATA_W-1:0] m_tdata;

    // shadow copy of the ring
    logic [rsol_pkg::LEN_W-1:0]    ring_len    [DEPTH];
    logic [rsol_pkg::HANDLE_W-1:0] ring_handle [DEPTH];
    int                            wr_ptr       = 0;
    int                            old_ptr      = 0;
    bit                            ring_is_full = 1'b0;

    rsol_pkg::result_t expected_results [$];
    dir_row_t          dir_rows [$];
    int                error_count  = 0;
    int                results_seen = 0;
    int                idle_cycles  = 0;

    ring_entry_store_offset_lookup #(
        .ENTRIES (DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int entry_count();
        if (ring_is_full)
            return DEPTH;
        return (wr_ptr - old_ptr + DEPTH) % DEPTH;
    endfunction

    // byte position where the k-th stored entry (oldest first) begins
    function automatic logic [63:0] entry_start(input int k);
        logic [63:0] acc;
        int          s;
        acc = '0;
        s   = old_ptr;
        for (int i = 0; i < k; i++)
        begin
            acc = acc + 64'(ring_len[s]);
            s   = (s + 1) % DEPTH;
        end
        return acc;
    endfunction

    function automatic rsol_pkg::result_t predict_result(
        input logic                          kind,
        input logic [rsol_pkg::LEN_W-1:0]    len,
        input logic [rsol_pkg::HANDLE_W-1:0] hnd,
        input logic [rsol_pkg::OFFSET_W-1:0] off);
        rsol_pkg::result_t r;
        logic [63:0]       start;
        logic [63:0]       stop;
        int                s;
        int                n;
        r = '0;
        if (kind == rsol_pkg::KIND_ADD)
        begin
            if (len != '0 && hnd != '0)
            begin
                if (ring_is_full)
                begin
                    r.evicted_valid  = 1'b1;
                    r.evicted_handle = ring_handle[old_ptr];
                    old_ptr          = (old_ptr + 1) % DEPTH;
                end
                ring_len[wr_ptr]    = len;
                ring_handle[wr_ptr] = hnd;
                wr_ptr              = (wr_ptr + 1) % DEPTH;
                if (wr_ptr == old_ptr)
                    ring_is_full = 1'b1;
                r.add_accepted = 1'b1;
            end
        end
        else
        begin
            n     = entry_count();
            s     = old_ptr;
            start = '0;
            for (int i = 0; i < n; i++)
            begin
                stop = start + 64'(ring_len[s]);
                if (64'(off) < stop)
                begin
                    r.found         = 1'b1;
                    r.found_slot    = rsol_pkg::SLOT_OUT_W'(s);
                    r.found_handle  = ring_handle[s];
                    r.byte_in_entry = off - start[31:0];
                    return r;
                end
                start = stop;
                s     = (s + 1) % DEPTH;
            end
        end
        return r;
    endfunction

    function automatic rsol_pkg::result_t mk_res(
        input bit                              acc,
        input bit                              ev,
        input logic [rsol_pkg::HANDLE_W-1:0]   evh,
        input bit                              fnd,
        input logic [rsol_pkg::SLOT_OUT_W-1:0] sl,
        input logic [rsol_pkg::HANDLE_W-1:0]   fh,
        input logic [rsol_pkg::OFFSET_W-1:0]   bie);
        rsol_pkg::result_t r;
        r.add_accepted   = acc;
        r.evicted_valid  = ev;
        r.evicted_handle = evh;
        r.found          = fnd;
        r.found_slot     = sl;
        r.found_handle   = fh;
        r.byte_in_entry  = bie;
        return r;
    endfunction

    function automatic void add_row(
        input logic                          kind,
        input logic [rsol_pkg::LEN_W-1:0]    len,
        input logic [rsol_pkg::HANDLE_W-1:0] hnd,
        input logic [rsol_pkg::OFFSET_W-1:0] off,
        input bit                            typed,
        input rsol_pkg::result_t             want);
        dir_row_t row;
        row.kind  = kind;
        row.len   = len;
        row.hnd   = hnd;
        row.off   = off;
        row.typed = typed;
        row.want  = want;
        dir_rows.push_back(row);
    endfunction

    // mostly short, now and then long
    function automatic int pick_gap();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (error_count < 100)
            $display("mismatch on result %0d: %s got %h want %h",
                     results_seen, what, got, want);
        error_count++;
    endtask

    task automatic push_item(input logic                          kind,
                             input logic [rsol_pkg::LEN_W-1:0]    len,
                             input logic [rsol_pkg::HANDLE_W-1:0] hnd,
                             input logic [rsol_pkg::OFFSET_W-1:0] off,
                             input bit                            typed,
                             input rsol_pkg::result_t             typed_res);
        rsol_pkg::result_t predicted;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {off, hnd, len};
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        predicted = predict_result(kind, len, hnd, off);
        expected_results.push_back(typed ? typed_res : predicted);
    endtask

    task automatic sender_pause(input bit burst);
        int gap;
        gap = 0;
        if (!burst && $urandom_range(0, 99) < 40)
            gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    always @(posedge clk)
    begin : check_result
        rsol_pkg::result_t got;
        rsol_pkg::result_t want;
        if (rst_n && m_tvalid === 1'b1 && m_tready)
        begin
            got = rsol_pkg::result_t'(m_tdata[$bits(rsol_pkg::result_t)-1:0]);
            if (expected_results.size() == 0)
                report_mismatch("transfer with nothing expected", m_tdata[31:0], '0);
            else
            begin
                want = expected_results.pop_front();
                if (got.add_accepted !== want.add_accepted)
                    report_mismatch("add_accepted", 32'(got.add_accepted),
                                    32'(want.add_accepted));
                if (got.evicted_valid !== want.evicted_valid)
                    report_mismatch("evicted_valid", 32'(got.evicted_valid),
                                    32'(want.evicted_valid));
                if (got.evicted_handle !== want.evicted_handle)
                    report_mismatch("evicted_handle", got.evicted_handle,
                                    want.evicted_handle);
                if (got.found !== want.found)
                    report_mismatch("found", 32'(got.found), 32'(want.found));
                if (got.found_slot !== want.found_slot)
                    report_mismatch("found_slot", 32'(got.found_slot), 32'(want.found_slot));
                if (got.found_handle !== want.found_handle)
                    report_mismatch("found_handle", got.found_handle, want.found_handle);
                if (got.byte_in_entry !== want.byte_in_entry)
                    report_mismatch("byte_in_entry", got.byte_in_entry, want.byte_in_entry);
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver: random stalls, quiet stretches, and two long hold-offs that
    // let the output register fill and back up the input
    initial
    begin : drive_ready
        int holds_done;
        int loops;
        bit quiet;
        holds_done = 0;
        loops      = 0;
        quiet      = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (holds_done < 2 && results_seen >= (holds_done + 1) * 700)
            begin
                holds_done++;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 99) < 25)
            begin
                m_tready <= 1'b0;
                repeat (pick_gap()) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            loops++;
            if (loops % 200 == 0)
                quiet = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin : stimulus
        rsol_pkg::result_t             zero_res;
        rsol_pkg::result_t             add_ok;
        logic                          kind;
        logic [rsol_pkg::LEN_W-1:0]    len;
        logic [rsol_pkg::HANDLE_W-1:0] hnd;
        logic [rsol_pkg::OFFSET_W-1:0] off;
        logic [63:0]                   total;
        logic [63:0]                   b;
        int                            len_mode;
        int                            choice;
        int                            pick;
        int                            k;
        bit                            burst;

        zero_res = '0;
        add_ok   = mk_res(1'b1, 1'b0, '0, 1'b0, '0, '0, '0);
        len_mode = 0;
        burst    = 1'b0;

        // empty ring, rejected adds, widest entry, then fill and overwrite
        add_row(rsol_pkg::KIND_FIND, '0, '0, '0, 1'b1, zero_res);
        add_row(rsol_pkg::KIND_FIND, '1, '1, '1, 1'b1, zero_res);
        add_row(rsol_pkg::KIND_ADD, '0, 32'h1, '0, 1'b1, zero_res);
        add_row(rsol_pkg::KIND_ADD, 32'h1, '0, '1, 1'b1, zero_res);
        add_row(rsol_pkg::KIND_ADD, '0, '0, '0, 1'b1, zero_res);
        add_row(rsol_pkg::KIND_ADD, '1, '1, '0, 1'b1, add_ok);
        add_row(rsol_pkg::KIND_FIND, '0, '0, 32'hFFFF_FFFE, 1'b1,
                mk_res(1'b0, 1'b0, '0, 1'b1, '0, '1, 32'hFFFF_FFFE));
        add_row(rsol_pkg::KIND_FIND, '0, '0, '1, 1'b1, zero_res);
        for (int s = 1; s < DEPTH; s++)
            add_row(rsol_pkg::KIND_ADD, 32'h1, 32'(s + 1), '1, 1'b1, add_ok);
        add_row(rsol_pkg::KIND_ADD, 32'h7, 32'hCAFE, '0, 1'b1,
                mk_res(1'b1, 1'b1, '1, 1'b0, '0, '0, '0));
        add_row(rsol_pkg::KIND_FIND, '0, '0, '0, 1'b0, zero_res);
        add_row(rsol_pkg::KIND_FIND, '0, '0, 32'(DEPTH - 1), 1'b0, zero_res);
        add_row(rsol_pkg::KIND_FIND, '0, '0, 32'(DEPTH + 5), 1'b0, zero_res);
        add_row(rsol_pkg::KIND_FIND, '0, '0, '1, 1'b0, zero_res);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            push_item(dir_rows[r].kind, dir_rows[r].len, dir_rows[r].hnd,
                      dir_rows[r].off, dir_rows[r].typed, dir_rows[r].want);
            sender_pause(1'b0);
        end

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            if (n % 150 == 0)
            begin
                len_mode = $urandom_range(0, 2);
                burst    = ($urandom_range(0, 3) == 0);
            end
            choice = $urandom_range(0, 99);
            if (choice < 45)
            begin
                kind = rsol_pkg::KIND_ADD;
                case (len_mode)
                    0: len = $urandom_range(1, 16);
                    1: len = $urandom_range(1, 1000);
                    default:
                    begin
                        if ($urandom_range(0, 9) == 0)
                            len = $urandom();
                        else
                            len = $urandom_range(1, 64);
                    end
                endcase
                if (len == '0)
                    len = 32'h1;
                hnd = $urandom();
                if (hnd == '0)
                    hnd = 32'h1;
                off = $urandom();
            end
            else if (choice < 50)
            begin
                // zero length, null handle, or both
                kind = rsol_pkg::KIND_ADD;
                pick = $urandom_range(0, 2);
                len  = (pick == 1) ? ($urandom() | 32'h1) : '0;
                hnd  = (pick == 0) ? ($urandom() | 32'h1) : '0;
                off  = $urandom();
            end
            else
            begin
                kind  = rsol_pkg::KIND_FIND;
                len   = $urandom();
                hnd   = $urandom();
                total = entry_start(entry_count());
                pick  = $urandom_range(0, 99);
                if (total == '0 || pick < 15)
                    off = $urandom();
                else if (pick < 30)
                    // just past the stored data
                    off = (total <= 64'hFFFF_FFFF) ? total[31:0] : $urandom();
                else if (pick < 55)
                begin
                    // first or last byte of a stored entry
                    k = $urandom_range(0, entry_count() - 1);
                    b = entry_start(k);
                    if (pick % 2 == 1)
                        b = b + 64'(ring_len[(old_ptr + k) % DEPTH]) - 64'h1;
                    off = (b > 64'hFFFF_FFFF) ? $urandom() : b[31:0];
                end
                else if (total > 64'hFFFF_FFFF)
                    off = $urandom();
                else
                    off = $urandom_range(0, total[31:0] - 32'h1);
            end
            push_item(kind, len, hnd, off, 1'b0, zero_res);
            sender_pause(burst);
        end
        s_tvalid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DEPTH + 5) @(posedge clk);

        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
